// File: rtl/core/i2da_pkg.sv
// i2da_pkg: shared types and constants of the 64-bit binary to decimal ascii unit
// no dependencies; imported by every module of the unit
package i2da_pkg;

    localparam int VALUE_W        = 64;
    localparam int CHAR_W         = 6;
    localparam int DIGIT_SLOTS    = 20;
    localparam int BCD_W          = DIGIT_SLOTS * 4;
    localparam int BITS_PER_STEP  = 4;
    localparam int CONV_STEPS     = VALUE_W / BITS_PER_STEP;
    localparam int STEP_CNT_W     = $clog2(CONV_STEPS);
    localparam int QUEUE_DEPTH    = 2;
    localparam int MAX_DIGITS_DEF = 20;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] ASCII_MINUS = CHAR_W'(45);

    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_item;

    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } t_conv_res;

endpackage

// File: rtl/core/i2da_front.sv
// i2da_front: takes the sign mode and raw word, produces sign flag and magnitude
// depends on i2da_pkg
module i2da_front (
    input  logic                    i_cmd,
    input  logic [63:0]             i_value_bits,
    output i2da_pkg::t_item         o_item
);
    import i2da_pkg::*;

    logic neg;

    always_comb begin
        neg        = i_cmd & i_value_bits[VALUE_W-1];
        o_item.neg = neg;
        o_item.mag = neg ? (VALUE_W'(0) - i_value_bits) : i_value_bits;
    end

endmodule

// File: rtl/core/i2da_queue.sv
// i2da_queue: short queue of classified items between front and converter
// depends on i2da_pkg
module i2da_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  i2da_pkg::t_item i_push_item,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output i2da_pkg::t_item o_pop_item
);
    import i2da_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               push, pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// File: rtl/core/i2da_conv.sv
// i2da_conv: iterative binary to bcd converter, four magnitude bits per cycle
// depends on i2da_pkg
module i2da_conv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    output logic                o_item_ready,
    input  i2da_pkg::t_item     i_item,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output i2da_pkg::t_conv_res o_res
);
    import i2da_pkg::*;

    // shift-add-3 over one group of input bits
    function automatic logic [BCD_W-1:0] dabble(
        input logic [BCD_W-1:0]         bcd,
        input logic [BITS_PER_STEP-1:0] bits
    );
        logic [BCD_W-1:0] x;
        x = bcd;
        for (int s = 0; s < BITS_PER_STEP; s++) begin
            for (int d = 0; d < DIGIT_SLOTS; d++) begin
                if (x[d*4 +: 4] >= 4'd5) begin
                    x[d*4 +: 4] = x[d*4 +: 4] + 4'd3;
                end
            end
            x = {x[BCD_W-2:0], bits[BITS_PER_STEP-1-s]};
        end
        return x;
    endfunction

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [STEP_CNT_W-1:0]  r_cnt, n_cnt;
    logic [VALUE_W-1:0]     r_bin, n_bin;
    logic [BCD_W-1:0]       r_bcd, n_bcd;
    logic                   r_neg, n_neg;

    assign o_item_ready = !r_busy && (!r_done || i_res_ready);
    assign o_res_valid  = r_done;
    assign o_res.neg    = r_neg;
    assign o_res.bcd    = r_bcd;

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_cnt  = r_cnt;
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_neg  = r_neg;
        if (r_busy) begin
            n_bcd = dabble(r_bcd, r_bin[VALUE_W-1 -: BITS_PER_STEP]);
            n_bin = {r_bin[VALUE_W-BITS_PER_STEP-1:0], BITS_PER_STEP'(0)};
            n_cnt = r_cnt + STEP_CNT_W'(1);
            if (r_cnt == STEP_CNT_W'(CONV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else begin
            if (r_done && i_res_ready) begin
                n_done = 1'b0;
            end
            if (i_item_valid && o_item_ready) begin
                n_busy = 1'b1;
                n_cnt  = '0;
                n_bin  = i_item.mag;
                n_bcd  = '0;
                n_neg  = i_item.neg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_neg <= n_neg;
    end

endmodule

// File: rtl/core/i2da_emit.sv
// i2da_emit: strips leading zeros and sends the text one character per transaction
// depends on i2da_pkg
module i2da_emit #(
    parameter int MAX_DIGITS = i2da_pkg::MAX_DIGITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_res_valid,
    output logic                        o_res_ready,
    input  i2da_pkg::t_conv_res         i_res,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [i2da_pkg::CHAR_W-1:0] o_text_char,
    output logic                        o_last_char
);
    import i2da_pkg::*;

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic [MAX_DIGITS-1:0][3:0] r_digits, n_digits;
    logic [IDX_W-1:0]           r_idx, n_idx;
    logic                       r_neg, n_neg;
    logic                       r_busy, n_busy;
    logic                       r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]          r_char, n_char;
    logic                       r_last, n_last;
    logic [IDX_W-1:0]           top_idx;
    logic                       out_free;
    logic                       finishing;

    assign o_valid     = r_out_valid;
    assign o_text_char = r_char;
    assign o_last_char = r_last;

    // highest nonzero kept digit, zero when all are zero
    always_comb begin
        top_idx = '0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (i_res.bcd[i*4 +: 4] != 4'd0) begin
                top_idx = IDX_W'(i);
            end
        end
    end

    assign out_free    = !r_out_valid || i_ready;
    assign finishing   = r_busy && out_free && !r_neg && (r_idx == '0);
    assign o_res_ready = !r_busy || finishing;

    always_comb begin
        n_digits    = r_digits;
        n_idx       = r_idx;
        n_neg       = r_neg;
        n_busy      = r_busy;
        n_out_valid = r_out_valid && !i_ready;
        n_char      = r_char;
        n_last      = r_last;
        if (r_busy && out_free) begin
            n_out_valid = 1'b1;
            if (r_neg) begin
                n_char = ASCII_MINUS;
                n_last = 1'b0;
                n_neg  = 1'b0;
            end else begin
                n_char = ASCII_ZERO + CHAR_W'(r_digits[r_idx]);
                n_last = (r_idx == '0);
                if (r_idx == '0) begin
                    n_busy = 1'b0;
                end else begin
                    n_idx = r_idx - IDX_W'(1);
                end
            end
        end
        if (i_res_valid && o_res_ready) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                n_digits[i] = i_res.bcd[i*4 +: 4];
            end
            n_idx  = top_idx;
            n_neg  = i_res.neg;
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_neg       <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            r_neg       <= n_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digits <= n_digits;
        r_idx    <= n_idx;
        r_char   <= n_char;
        r_last   <= n_last;
    end

endmodule

// File: rtl/core/int64_to_decimal_ascii_unit.sv
// int64_to_decimal_ascii_unit: 64-bit signed/unsigned word to decimal ascii text
// depends on i2da_pkg, i2da_front, i2da_queue, i2da_conv, i2da_emit
//
//   channel   handshake              payload
//   input     i_valid / o_ready      i_cmd, i_value_bits
//   output    o_valid / i_ready      o_text_char, o_last_char
//
// the converter shifts in 4 magnitude bits per cycle and loads no new word while busy
// unless held, the emitter sends a char per cycle, up to 21 a word, from its digit copy
// the converter can work on the next word while the emitter still sends the last one
// reset clears pointers, counts and busy/done/valid flags; no clearing pass is needed
// either side may stall; a two-entry queue sits between front and converter
module int64_to_decimal_ascii_unit #(
    parameter int MAX_DIGITS = i2da_pkg::MAX_DIGITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_cmd,
    input  logic [63:0]                 i_value_bits,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [i2da_pkg::CHAR_W-1:0] o_text_char,
    output logic                        o_last_char
);
    import i2da_pkg::*;

    t_item     front_item;
    t_item     queue_item;
    logic      queue_valid;
    logic      queue_ready;
    t_conv_res conv_res;
    logic      conv_valid;
    logic      conv_ready;

    i2da_front u_front (
        .i_cmd        (i_cmd),
        .i_value_bits (i_value_bits),
        .o_item       (front_item)
    );

    i2da_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (i_valid),
        .o_push_ready (o_ready),
        .i_push_item  (front_item),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_pop_item   (queue_item)
    );

    i2da_conv u_conv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (queue_valid),
        .o_item_ready (queue_ready),
        .i_item       (queue_item),
        .o_res_valid  (conv_valid),
        .i_res_ready  (conv_ready),
        .o_res        (conv_res)
    );

    i2da_emit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (conv_valid),
        .o_res_ready (conv_ready),
        .i_res       (conv_res),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

endmodule
